// ===== src/independent_watchdog_timer_top_defines.svh =====
// assertion macros for the independent watchdog timer
// needs clk_i and rst_ni in the scope of the module that uses them
`ifndef INDEPENDENT_WATCHDOG_TIMER_TOP_DEFINES_SVH
`define INDEPENDENT_WATCHDOG_TIMER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define IWDT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define IWDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/iwdt_pkg.sv =====
// types and constants of the independent watchdog timer
// no dependencies
package iwdt_pkg;

  localparam int unsigned CountBits = 12;
  localparam int unsigned WaitBits  = 3;
  localparam int unsigned PresBits  = 8;
  localparam int unsigned DataBits  = 16;

  localparam logic [WaitBits-1:0]  UpdateTicks = 3'd5;
  localparam logic [2:0]           PrCap       = 3'd6;
  localparam logic [DataBits-1:0]  KeyStart    = 16'hCCCC;
  localparam logic [DataBits-1:0]  KeyUnlock   = 16'h5555;
  localparam logic [DataBits-1:0]  KeyReload   = 16'hAAAA;
  localparam logic [CountBits-1:0] CountInit   = {CountBits{1'b1}};

  typedef enum logic [1:0] {
    OpWrite = 2'd0,
    OpRead  = 2'd1,
    OpTick  = 2'd2
  } iwdt_op_e;

  typedef enum logic [1:0] {
    AddrKey    = 2'd0,
    AddrPresc  = 2'd1,
    AddrReload = 2'd2,
    AddrStatus = 2'd3
  } iwdt_addr_e;

  typedef struct packed {
    iwdt_op_e            operation;
    iwdt_addr_e          reg_addr;
    logic [DataBits-1:0] write_data;
  } iwdt_req_t;

  typedef struct packed {
    logic [DataBits-1:0] read_data;
    logic                watchdog_reset;
    logic                running;
  } iwdt_rsp_t;

  // controls from the register file to the counter
  typedef struct packed {
    logic                 tick;
    logic                 load;
    logic                 started;
    logic [2:0]           sel;
    logic [CountBits-1:0] load_value;
  } iwdt_ctrl_t;

endpackage

// ===== src/iwdt_counter.sv =====
// prescaler and down-counter of the independent watchdog timer
// depends on iwdt_pkg
module iwdt_counter import iwdt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  iwdt_ctrl_t ctrl_i,
  output logic       expire_o
);

  logic [PresBits-1:0]  pres_q, pres_d;
  logic [CountBits-1:0] down_q, down_d;
  logic [2:0]           sel_cap;
  logic [PresBits-1:0]  div_m1;
  logic                 wrap;
  logic                 active;

  always_comb begin
    sel_cap = (ctrl_i.sel > PrCap) ? PrCap : ctrl_i.sel;
    // divide minus one: 4 << sel, less one
    div_m1  = PresBits'((9'd4 << sel_cap) - 9'd1);
    wrap    = (pres_q >= div_m1);
    active  = ctrl_i.tick && ctrl_i.started;
    expire_o = active && wrap && (down_q == '0);
  end

  always_comb begin
    pres_d = pres_q;
    down_d = down_q;
    if (active) begin
      if (wrap) begin
        pres_d = '0;
        down_d = (down_q == '0) ? CountInit : down_q - 1'b1;
      end else begin
        pres_d = pres_q + 1'b1;
      end
    end else if (ctrl_i.load) begin
      down_d = ctrl_i.load_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pres_q <= '0;
      down_q <= CountInit;
    end else begin
      pres_q <= pres_d;
      down_q <= down_d;
    end
  end

endmodule

// ===== src/iwdt_regs.sv =====
// key, prescaler, reload and status registers of the watchdog
// depends on iwdt_pkg and the assertion macro header
`include "independent_watchdog_timer_top_defines.svh"
module iwdt_regs import iwdt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  iwdt_req_t  req_i,
  input  logic       expire_i,
  output iwdt_ctrl_t ctrl_o,
  output iwdt_rsp_t  rsp_o
);

  logic                 started_q, started_d;
  logic                 unlocked_q, unlocked_d;
  logic [2:0]           presc_q, presc_d;
  logic [CountBits-1:0] reload_q, reload_d;
  logic [WaitBits-1:0]  presc_wait_q, presc_wait_d;
  logic [WaitBits-1:0]  reload_wait_q, reload_wait_d;
  logic                 is_write, is_read, is_tick;

  always_comb begin
    is_write = fire_i && (req_i.operation == OpWrite);
    is_read  = fire_i && (req_i.operation == OpRead);
    is_tick  = fire_i && (req_i.operation == OpTick);
  end

  always_comb begin
    ctrl_o.tick       = is_tick;
    ctrl_o.load       = is_write && (req_i.reg_addr == AddrKey) &&
                        (req_i.write_data == KeyReload);
    ctrl_o.started    = started_q;
    ctrl_o.sel        = presc_q;
    ctrl_o.load_value = reload_q;
  end

  always_comb begin
    started_d     = started_q;
    unlocked_d    = unlocked_q;
    presc_d       = presc_q;
    reload_d      = reload_q;
    presc_wait_d  = presc_wait_q;
    reload_wait_d = reload_wait_q;
    if (is_write) begin
      unique case (req_i.reg_addr)
        AddrKey: begin
          unlocked_d = (req_i.write_data == KeyUnlock);
          if (req_i.write_data == KeyStart) started_d = 1'b1;
        end
        AddrPresc: begin
          if (unlocked_q) begin
            presc_d      = req_i.write_data[2:0];
            presc_wait_d = UpdateTicks;
          end
        end
        AddrReload: begin
          if (unlocked_q) begin
            reload_d      = req_i.write_data[CountBits-1:0];
            reload_wait_d = UpdateTicks;
          end
        end
        default: ;
      endcase
    end else if (is_tick) begin
      if (presc_wait_q != '0) presc_wait_d = presc_wait_q - 1'b1;
      if (reload_wait_q != '0) reload_wait_d = reload_wait_q - 1'b1;
    end
    // expiry returns the whole block to its reset state
    if (expire_i) begin
      started_d     = 1'b0;
      unlocked_d    = 1'b0;
      presc_d       = '0;
      reload_d      = CountInit;
      presc_wait_d  = '0;
      reload_wait_d = '0;
    end
  end

  always_comb begin
    rsp_o.read_data = '0;
    if (is_read) begin
      unique case (req_i.reg_addr)
        AddrKey:    rsp_o.read_data = '0;
        AddrPresc:  rsp_o.read_data = DataBits'(presc_q);
        AddrReload: rsp_o.read_data = DataBits'(reload_q);
        AddrStatus: rsp_o.read_data = DataBits'({reload_wait_q != '0, presc_wait_q != '0});
        default:    rsp_o.read_data = '0;
      endcase
    end
    rsp_o.watchdog_reset = expire_i;
    rsp_o.running        = started_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q     <= 1'b0;
      unlocked_q    <= 1'b0;
      presc_q       <= '0;
      reload_q      <= CountInit;
      presc_wait_q  <= '0;
      reload_wait_q <= '0;
    end else begin
      started_q     <= started_d;
      unlocked_q    <= unlocked_d;
      presc_q       <= presc_d;
      reload_q      <= reload_d;
      presc_wait_q  <= presc_wait_d;
      reload_wait_q <= reload_wait_d;
    end
  end

  `IWDT_ASSERT(a_wait_bounded, 1'b1,
    (presc_wait_q <= UpdateTicks) && (reload_wait_q <= UpdateTicks), "busy count overran")
  `IWDT_ASSERT_NEXT(a_started_sticky, started_q && !(is_tick && expire_i), started_q,
    "watchdog stopped without expiry")
  `IWDT_ASSERT_NEXT(a_locked_presc,
    is_write && (req_i.reg_addr == AddrPresc) && !unlocked_q, $stable(presc_q),
    "locked prescaler write took effect")

endmodule

// ===== src/independent_watchdog_timer_top.sv =====
// top level of the independent watchdog timer: request and result registers
// depends on iwdt_pkg, iwdt_regs, iwdt_counter and the assertion macro header
//
// usage:
//   requests (req_i: operation, reg_addr, write_data) enter on req_valid_i and
//   are taken at a rising edge where req_valid_i is high and req_stall_o low.
//   operation is a register write, a register read or one slow-clock tick.
//   every request gives exactly one result (rsp_o: read_data, watchdog_reset,
//   running) on rsp_valid_o, taken when rsp_stall_i is low.
// stages: request register then result register; the register and counter
//   update is one pass of decode and 12-bit decrement logic between them.
// throughput: one request per cycle, sustained while results are taken.
// stall: a stalled result holds in the result register; one more request
//   waits in the request register, then req_stall_o rises until the result
//   is taken.
// reset: rst_ni clears both stages and puts the watchdog in its stopped,
//   locked state with reload and counter at all ones. an expiry on a tick
//   gives watchdog_reset in that result and returns the block to that state.
`include "independent_watchdog_timer_top_defines.svh"
module independent_watchdog_timer_top import iwdt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_stall_o,
  input  iwdt_req_t req_i,
  output logic      rsp_valid_o,
  input  logic      rsp_stall_i,
  output iwdt_rsp_t rsp_o
);

  logic       in_valid_q;
  iwdt_req_t  in_q;
  logic       out_valid_q;
  iwdt_rsp_t  out_q;
  logic       advance;
  logic       accept;
  logic       expire;
  iwdt_ctrl_t ctrl;
  iwdt_rsp_t  rsp_d;

  always_comb begin
    advance     = in_valid_q && (!out_valid_q || !rsp_stall_i);
    req_stall_o = in_valid_q && !advance;
    accept      = req_valid_i && !req_stall_o;
  end

  iwdt_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .req_i    (in_q),
    .expire_i (expire),
    .ctrl_o   (ctrl),
    .rsp_o    (rsp_d)
  );

  iwdt_counter u_counter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .expire_o (expire)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) in_valid_q <= 1'b1;
      else if (advance) in_valid_q <= 1'b0;
      if (advance) out_valid_q <= 1'b1;
      else if (!rsp_stall_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) in_q <= req_i;
    if (advance) out_q <= rsp_d;
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

  `IWDT_ASSERT(a_reset_stops, rsp_valid_o && rsp_o.watchdog_reset, !rsp_o.running,
    "expiry result shows watchdog running")
  `IWDT_ASSERT_NEXT(a_result_lands, advance, rsp_valid_o, "request advanced without result")

endmodule
